>>> rtl/rpip_pkg.sv
// Shared types, character codes and the digit decoder of the radix-prefixed integer parser.
`timescale 1ns / 1ps

package rpip_pkg;

    // Widths of the word fields.
    localparam int CH_W           = 8;
    localparam int OUT_W          = 32;
    localparam int VALUE_BITS_DEF = 32;

    // Character codes that steer the parse.
    localparam logic [CH_W-1:0] CH_DIGIT_0 = 8'h30;
    localparam logic [CH_W-1:0] CH_DIGIT_9 = 8'h39;
    localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CH_W-1:0] CH_UPPER_F = 8'h46;
    localparam logic [CH_W-1:0] CH_LOWER_X = 8'h78;
    localparam logic [CH_W-1:0] CH_UPPER_X = 8'h58;
    localparam logic [CH_W-1:0] CH_MINUS   = 8'h2D;

    // Parse phase of the current string.
    typedef enum logic [2:0] {
        PH_START,
        PH_ZERO,
        PH_SIGN,
        PH_DIGITS,
        PH_ERROR
    } phase_t;

    // Number base in force.
    typedef enum logic [4:0] {
        RADIX_8  = 5'd8,
        RADIX_10 = 5'd10,
        RADIX_16 = 5'd16
    } radix_t;

    // Decoded digit: ok is low for a character that is no digit.
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } digit_t;

    // Maps '0'-'9' and 'A'-'F' to 0..15.
    function automatic digit_t digit_of(input logic [CH_W-1:0] c);
        digit_t d;
        logic [CH_W-1:0] diff;
        d    = '{ok: 1'b0, val: 4'd0};
        diff = '0;
        if (c inside {[CH_DIGIT_0:CH_DIGIT_9]})
        begin
            diff  = c - CH_DIGIT_0;
            d.ok  = 1'b1;
            d.val = diff[3:0];
        end
        else if (c inside {[CH_UPPER_A:CH_UPPER_F]})
        begin
            diff  = c - CH_UPPER_A + 8'd10;
            d.ok  = 1'b1;
            d.val = diff[3:0];
        end
        return d;
    endfunction

endpackage

>>> rtl/rpip_in_if.sv
// Character channel: one ASCII character and its last-character mark per word.
`timescale 1ns / 1ps

interface rpip_in_if import rpip_pkg::*; ();

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);

endinterface

>>> rtl/rpip_out_if.sv
// Result channel: the parsed signed value and the bad character flag per word.
`timescale 1ns / 1ps

interface rpip_out_if import rpip_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] value;
    logic                    bad_char;

    modport source (output valid, output value, output bad_char, input ready);
    modport sink   (input valid, input value, input bad_char, output ready);

endinterface

>>> rtl/radix_prefixed_integer_parser_top.sv
// Radix-prefixed integer parser: turns a character stream into a signed value per string.
// Result path: the last character of a string is held in the input register, and its result word
// is loaded into the result register when that character moves on.
// Throughput: one character per cycle; input stalls only while the held character ends a
// string and the previous result word is still waiting to be taken.
// Reset: asynchronous and active low; it empties both registers and returns the parse state
// to the start of a string in base ten with a zero accumulator.
`timescale 1ns / 1ps

module radix_prefixed_integer_parser_top import rpip_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rpip_in_if.sink    chars,
    rpip_out_if.source result
);

    localparam int VB = VALUE_BITS;

    // Input register.
    logic            in_vld_reg;
    logic [CH_W-1:0] in_ch_reg;
    logic            in_last_reg;

    // Parse state.
    phase_t        phase_reg,  phase_next;
    radix_t        radix_reg,  radix_next;
    logic [VB-1:0] acc_reg,    acc_next;
    logic          neg_reg,    neg_next;

    // Result register.
    logic                    out_vld_reg;
    logic signed [OUT_W-1:0] value_reg,   value_next;
    logic                    bad_reg,     bad_next;

    logic          step_go;
    logic          take_digit;
    logic          clear_acc;
    digit_t        dig;
    logic [VB-1:0] acc_base;
    logic [VB-1:0] acc_scaled;
    logic [VB-1:0] signed_acc;
    logic [VB+OUT_W-1:0] ext_acc;

    // A held character moves on unless it ends a string while a result still waits.
    assign step_go     = in_vld_reg && (!in_last_reg || !out_vld_reg || result.ready);
    assign chars.ready = !in_vld_reg || step_go;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            in_vld_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
        begin
            in_ch_reg   <= chars.ch;
            in_last_reg <= chars.last;
        end
    end

    // Next parse state for the held character.
    always_comb
    begin
        phase_next = phase_reg;
        radix_next = radix_reg;
        neg_next   = neg_reg;
        take_digit = 1'b0;
        clear_acc  = 1'b0;
        case (phase_reg)
            PH_START:
            begin
                radix_next = RADIX_10;
                if (in_ch_reg == CH_DIGIT_0)
                begin
                    phase_next = PH_ZERO;
                end
                else if (in_ch_reg == CH_MINUS)
                begin
                    neg_next   = 1'b1;
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    take_digit = 1'b1;
                end
            end
            PH_ZERO:
            begin
                if (in_ch_reg == CH_LOWER_X || in_ch_reg == CH_UPPER_X)
                begin
                    radix_next = RADIX_16;
                    phase_next = PH_SIGN;
                end
                else
                begin
                    // The leading zero is the first octal digit.
                    radix_next = RADIX_8;
                    clear_acc  = 1'b1;
                    take_digit = 1'b1;
                end
            end
            PH_SIGN:
            begin
                if (in_ch_reg == CH_MINUS)
                begin
                    neg_next   = 1'b1;
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    take_digit = 1'b1;
                end
            end
            PH_DIGITS:
            begin
                take_digit = 1'b1;
            end
            default:
            begin
                phase_next = PH_ERROR;
            end
        endcase

        if (take_digit)
        begin
            phase_next = dig.ok ? PH_DIGITS : PH_ERROR;
        end
    end

    // Accumulator step: multiply by the base with shifts and add the digit.
    assign dig      = digit_of(in_ch_reg);
    assign acc_base = clear_acc ? '0 : acc_reg;

    always_comb
    begin
        case (radix_next)
            RADIX_8:  acc_scaled = acc_base << 3;
            RADIX_16: acc_scaled = acc_base << 4;
            default:  acc_scaled = (acc_base << 3) + (acc_base << 1);
        endcase
        if (take_digit && dig.ok)
        begin
            acc_next = acc_scaled + {{(VB-4){1'b0}}, dig.val};
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    // Result word: apply the sign, extend or cut to the output width; a bad string gives zero.
    always_comb
    begin
        signed_acc = neg_next ? (~acc_next + {{(VB-1){1'b0}}, 1'b1}) : acc_next;
        ext_acc    = {{OUT_W{signed_acc[VB-1]}}, signed_acc};
        bad_next   = (phase_next == PH_ERROR);
        value_next = bad_next ? '0 : ext_acc[OUT_W-1:0];
    end

    // Parse state registers; the state returns to its reset value after each string.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            radix_reg <= RADIX_10;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
        end
        else if (step_go)
        begin
            if (in_last_reg)
            begin
                phase_reg <= PH_START;
                radix_reg <= RADIX_10;
                acc_reg   <= '0;
                neg_reg   <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                radix_reg <= radix_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (step_go && in_last_reg)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_go && in_last_reg)
        begin
            value_reg <= value_next;
            bad_reg   <= bad_next;
        end
    end

    assign result.valid    = out_vld_reg;
    assign result.value    = value_reg;
    assign result.bad_char = bad_reg;

endmodule

>>> rtl/rpip_checker.sv
// Port-level checks of the radix-prefixed integer parser and their binding to the top level.
`timescale 1ns / 1ps

module rpip_checker import rpip_pkg::*; (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [OUT_W-1:0] out_value,
    input logic                    out_bad_char
);

    // A string with a bad character always reports zero.
    a_bad_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_bad_char) |-> (out_value == '0))
        else $error("bad_char word carries a non-zero value");

    // Input stalls only behind a result word that is waiting to be taken.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a waiting result word");

    // A stalled result word stays and holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_value) && $stable(out_bad_char)))
        else $error("stalled result word changed or vanished");

    // The result channel is empty right after reset.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result word valid straight out of reset");

endmodule

bind radix_prefixed_integer_parser_top rpip_checker u_rpip_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (chars.valid),
    .in_ready     (chars.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_value    (result.value),
    .out_bad_char (result.bad_char)
);

>>> tb/rpip_result_checker.sv
// Checker that predicts and compares the result words of the radix-prefixed integer parser.
`timescale 1ns / 1ps

module rpip_result_checker import rpip_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    rpip_in_if   chars,
    rpip_out_if  result,
    output int   mismatches,
    output int   outstanding
);

    // One predicted result word.
    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic                    bad_char;
    } parsed_t;

    parsed_t expected_q[$];

    // Parse state of the string being predicted.
    phase_t           parse_phase;
    radix_t           base;
    logic [OUT_W-1:0] acc;
    logic             neg;

    // Prints one line for a mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    // Returns the parse state to the start of a string.
    task automatic clear_parse();
        parse_phase = PH_START;
        base        = RADIX_10;
        acc         = '0;
        neg         = 1'b0;
    endtask

    // Advances the predicted parse by one character and, on the last one, queues the
    // expected result word.
    task automatic parse_char(input logic [CH_W-1:0] c, input logic is_last);
        logic       want_digit;
        logic       digit_ok;
        logic [4:0] digit_val;
        parsed_t    res;
        want_digit = 1'b0;
        digit_ok   = 1'b1;
        digit_val  = '0;
        case (parse_phase)
            PH_START:
            begin
                base = RADIX_10;
                if (c == CH_DIGIT_0)
                    parse_phase = PH_ZERO;
                else if (c == CH_MINUS)
                begin
                    neg         = 1'b1;
                    parse_phase = PH_DIGITS;
                end
                else
                    want_digit = 1'b1;
            end
            PH_ZERO:
            begin
                if (c == CH_LOWER_X || c == CH_UPPER_X)
                begin
                    base        = RADIX_16;
                    parse_phase = PH_SIGN;
                end
                else
                begin
                    // The leading zero was an octal digit of value zero.
                    base       = RADIX_8;
                    acc        = '0;
                    want_digit = 1'b1;
                end
            end
            PH_SIGN:
            begin
                if (c == CH_MINUS)
                begin
                    neg         = 1'b1;
                    parse_phase = PH_DIGITS;
                end
                else
                    want_digit = 1'b1;
            end
            PH_DIGITS:
                want_digit = 1'b1;
            default:
                parse_phase = PH_ERROR;
        endcase

        // Digits 0-9 and A-F are taken in every base; anything else spoils the string.
        if (want_digit)
        begin
            if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
                digit_val = 5'(c - CH_DIGIT_0);
            else if (c >= CH_UPPER_A && c <= CH_UPPER_F)
                digit_val = 5'(c - CH_UPPER_A) + 5'd10;
            else
                digit_ok = 1'b0;
            if (digit_ok)
            begin
                acc         = acc * OUT_W'(base) + OUT_W'(digit_val);
                parse_phase = PH_DIGITS;
            end
            else
                parse_phase = PH_ERROR;
        end

        if (is_last)
        begin
            if (parse_phase == PH_ERROR)
            begin
                res.value    = '0;
                res.bad_char = 1'b1;
            end
            else
            begin
                res.value    = neg ? -acc : acc;
                res.bad_char = 1'b0;
            end
            expected_q.push_back(res);
            clear_parse();
        end
    endtask

    // Watches both channels: result words are checked before new characters are predicted.
    always @(posedge clk or negedge rst_n)
    begin
        parsed_t want;
        if (!rst_n)
        begin
            clear_parse();
            expected_q.delete();
            mismatches  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch($sformatf("result word %0d/%0b with nothing expected",
                                              result.value, result.bad_char));
                else
                begin
                    want = expected_q.pop_front();
                    if (result.value !== want.value)
                        report_mismatch($sformatf("value %0d, expected %0d",
                                                  result.value, want.value));
                    if (result.bad_char !== want.bad_char)
                        report_mismatch($sformatf("bad_char %0b, expected %0b",
                                                  result.bad_char, want.bad_char));
                end
            end
            if (chars.valid && chars.ready)
                parse_char(chars.ch, chars.last);
            outstanding <= expected_q.size();
        end
    end

endmodule

>>> tb/radix_prefixed_integer_parser_top_test.sv
// Top of the parser testbench: clock, reset, character stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module radix_prefixed_integer_parser_top_test;
    import rpip_pkg::*;

    localparam int LIMIT       = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_TAIL  = 8;

    // Byte codes at the ends of the character range.
    localparam logic [CH_W-1:0] CH_NUL  = 8'h00;
    localparam logic [CH_W-1:0] CH_HIGH = 8'hFF;

    typedef logic [CH_W-1:0] char_q_t[$];

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   chars_sent;
    int   cycle_count;
    int   src_idle_pct;
    int   snk_idle_pct;
    bit   hold_req;
    bit   hold_done;

    rpip_in_if  chars ();
    rpip_out_if result ();

    radix_prefixed_integer_parser_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars),
        .result (result)
    );

    rpip_result_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .chars       (chars),
        .result      (result),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Offers one character word, idling at random first, and waits until it is taken.
    task automatic send_char(input logic [CH_W-1:0] c, input logic is_last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            chars.valid <= 1'b0;
            chars.ch    <= CH_W'($urandom_range(255));
            @(posedge clk);
        end
        chars.valid <= 1'b1;
        chars.ch    <= c;
        chars.last  <= is_last;
        @(posedge clk);
        while (!chars.ready)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_string(input char_q_t s);
        foreach (s[i])
            send_char(s[i], i == s.size() - 1);
    endtask

    // Builds a random string: mostly well-formed numbers, some with one byte spoilt,
    // and some pure noise.
    function automatic char_q_t make_number();
        char_q_t    s;
        int         kind;
        int         form;
        int         ndig;
        int         pos;
        logic [3:0] d;
        kind = $urandom_range(99);
        if (kind >= 85)
        begin
            ndig = $urandom_range(1, 6);
            repeat (ndig)
                s.push_back(CH_W'($urandom_range(255)));
            return s;
        end
        form = $urandom_range(3);
        if (form == 1)
            s.push_back(CH_MINUS);
        else if (form == 2)
            s.push_back(CH_DIGIT_0);
        else if (form == 3)
        begin
            s.push_back(CH_DIGIT_0);
            s.push_back($urandom_range(1) ? CH_LOWER_X : CH_UPPER_X);
            if ($urandom_range(2) == 0)
                s.push_back(CH_MINUS);
        end
        // Long digit runs make the accumulator wrap.
        ndig = ($urandom_range(9) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 8);
        repeat (ndig)
        begin
            d = 4'($urandom_range(15));
            s.push_back(d < 10 ? CH_DIGIT_0 + CH_W'(d) : CH_UPPER_A + CH_W'(d - 10));
        end
        if (s.size() == 0)
            s.push_back(CH_DIGIT_0 + CH_W'($urandom_range(9)));
        if (kind >= 70)
        begin
            pos    = $urandom_range(s.size() - 1);
            s[pos] = CH_W'($urandom_range(255));
        end
        return s;
    endfunction

    // Stops offering words until every expected result word has come, then lets the
    // pipeline settle.
    task automatic wait_drained();
        chars.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL)
            @(posedge clk);
    endtask

    // Result side: random stalls, and one long hold-off counted here when asked for.
    initial
    begin
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                result.ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                hold_done = 1'b1;
            end
            else
                result.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Stimulus and verdict.
    initial
    begin
        rst_n        <= 1'b0;
        chars.valid  <= 1'b0;
        chars.ch     <= '0;
        chars.last   <= 1'b0;
        chars_sent   = 0;
        src_idle_pct = 29;
        snk_idle_pct = 86;
        hold_req     = 1'b0;
        hold_done    = 1'b0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed strings: lone zero, prefixes with no digits, a sign in octal,
        // a digit beyond its base, an octal number, a hex number, a negative number, a bad character
        // with more characters after it, and the lowest and highest byte codes.
        send_text("0");
        send_text("0x");
        send_text("-");
        send_text("0X-");
        send_text("0-");
        send_text("F");
        send_text("9");
        send_text("07");
        send_text("0xF");
        send_text("-1");
        send_text("1a0");
        send_char(CH_NUL, 1'b1);
        send_char(CH_HIGH, 1'b1);

        // Random strings with a slow receiver.
        while (chars_sent < 600)
            send_string(make_number());
        wait_drained();

        // Random strings with a slow sender.
        src_idle_pct = 86;
        snk_idle_pct = 29;
        while (chars_sent < 1200)
            send_string(make_number());
        wait_drained();

        // No idling, with one long receiver hold-off so that the input backs up.
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_req     = 1'b1;
        while (chars_sent < 1750)
            send_string(make_number());
        wait_drained();

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/rpip_pkg.sv
rtl/rpip_in_if.sv
rtl/rpip_out_if.sv
rtl/radix_prefixed_integer_parser_top.sv
rtl/rpip_checker.sv
tb/rpip_result_checker.sv
tb/radix_prefixed_integer_parser_top_test.sv
